// File: hw/rtl/csd_pkg.sv
// Package: widths, reset values, register indexes and queue entry type of the cone distance unit.
`default_nettype none
package csd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int CFG_W      = 23;
  localparam int PT_W       = 24;
  localparam int OUT_W      = 26;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // integer square root: radicand, root and partial remainder widths
  localparam int RAD_W    = 52;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int REM_W    = ROOT_W + 2;
  localparam int SQRT_LAT = ROOT_W;

  // signed numerators, their magnitudes, divisor and quotient
  localparam int NUM_W     = 49;
  localparam int MAG_W     = NUM_W - 1;
  localparam int LEN_W     = 24;
  localparam int QUO_W     = 27;
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int DIV_CMP_W = LEN_W + QUO_W;
  localparam int DIST_W    = QUO_W + 1;
  localparam int TY_W      = PT_W + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [CFG_W-1:0] RADIUS_RESET =
    CFG_W'(((64'd194 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [CFG_W-1:0] HEIGHT_RESET =
    CFG_W'((64'd7 << FRAC_BITS) / 64'd2);

  localparam logic signed [DIST_W-1:0] OUT_MAX =
    {{(DIST_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] OUT_MIN =
    {{(DIST_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS = 8'd0,
    REG_HEIGHT = 8'd1
  } cfg_reg_e;

  // classified item: base distance and, when sel, the legs of a corner distance
  typedef struct packed {
    logic signed [DIST_W-1:0] d0;
    logic                     sel;
    logic [PT_W-1:0]          a;
    logic [PT_W-1:0]          b;
  } cand_t;

endpackage
`default_nettype wire

// File: hw/rtl/cone_signed_distance.sv
// Top level: configuration registers, front pipeline, queue and back pipeline.
//
// Signed distance from a point to an upright cone (apex on the y axis at the
// height register, base circle of the radius register in y = 0), all values
// fixed point with 16 fraction bits, result saturated to 26 bits, negative
// inside. One item per cycle is taken and delivered while the queue is not full
// and the output is not stalled. The design holds three 26-stage square root
// pipelines and two 28-stage dividers. A four-entry queue sits between the
// front (roots, mantle and projection division) and the back (corner distance
// root and final max). Config writes are always ready and take effect at once;
// write only while no item is in flight.
`default_nettype none
module cone_signed_distance import csd_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [PT_W-1:0]  point_x_i,
  input  wire logic signed [PT_W-1:0]  point_y_i,
  input  wire logic signed [PT_W-1:0]  point_z_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [OUT_W-1:0]      signed_distance_o
);

  logic [CFG_W-1:0] radius_q, height_q;
  logic             push, pop, full, empty;
  cand_t            f_cand, q_cand;
  logic [OUT_W-1:0] back_dist;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RADIUS: radius_q <= cfg_data_i[CFG_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  csd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cone_radius_i (radius_q),
    .cone_height_i (height_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .full_i        (full),
    .push_o        (push),
    .cand_o        (f_cand)
  );

  csd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cand_i  (f_cand),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cand_o  (q_cand)
  );

  csd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .cand_i            (q_cand),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .signed_distance_o (back_dist)
  );

  assign signed_distance_o = $signed(back_dist);

endmodule
`default_nettype wire

// File: hw/rtl/csd_isqrt.sv
// Pipelined floor integer square root, one root bit per stage.
`default_nettype none
module csd_isqrt import csd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  output logic      [ROOT_W-1:0] root_o
);

  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RAD_W-1:0]  rad_q  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    assign cur   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          rem_q[i]  <= REM_W'(cur - trial);
          root_q[i] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= cur[REM_W-1:0];
          root_q[i] <= {root_in[ROOT_W-2:0], 1'b0};
        end
        rad_q[i] <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/csd_div.sv
// Pipelined restoring divider: signed numerator by unsigned divisor, one quotient bit per stage.
`default_nettype none
module csd_div import csd_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [LEN_W-1:0] den_i,
  output logic             [QUO_W-1:0] quo_o,
  output logic                         rem_nz_o,
  output logic                         neg_o
);

  logic [MAG_W-1:0] mag_q;
  logic [LEN_W-1:0] den0_q;
  logic             neg0_q;

  logic [MAG_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [LEN_W-1:0] den_q [QUO_W];
  logic             neg_q [QUO_W];

  logic signed [NUM_W-1:0] neg_num;
  assign neg_num = -num_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= num_i[NUM_W-1] ? neg_num[MAG_W-1:0] : num_i[MAG_W-1:0];
      den0_q <= den_i;
      neg0_q <= num_i[NUM_W-1];
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [MAG_W-1:0]     rem_in;
    logic [QUO_W-1:0]     quo_in;
    logic [LEN_W-1:0]     den_in;
    logic                 neg_in;
    logic [DIV_CMP_W-1:0] rem_ext;
    logic [DIV_CMP_W-1:0] sub;

    if (j == 0) begin : g_first
      assign rem_in = mag_q;
      assign quo_in = '0;
      assign den_in = den0_q;
      assign neg_in = neg0_q;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign den_in = den_q[j-1];
      assign neg_in = neg_q[j-1];
    end

    assign rem_ext = DIV_CMP_W'(rem_in);
    assign sub     = DIV_CMP_W'(den_in) << (QUO_W - 1 - j);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_ext >= sub) begin
          rem_q[j] <= MAG_W'(rem_ext - sub);
          quo_q[j] <= {quo_in[QUO_W-2:0], 1'b1};
        end else begin
          rem_q[j] <= rem_in;
          quo_q[j] <= {quo_in[QUO_W-2:0], 1'b0};
        end
        den_q[j] <= den_in;
        neg_q[j] <= neg_in;
      end
    end
  end

  assign quo_o    = quo_q[QUO_W-1];
  assign rem_nz_o = |rem_q[QUO_W-1];
  assign neg_o    = neg_q[QUO_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/csd_front.sv
// Front pipeline: radial distance, slant length, mantle and projection, case classification.
`default_nettype none
module csd_front import csd_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic       [CFG_W-1:0] cone_radius_i,
  input  wire logic       [CFG_W-1:0] cone_height_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic signed [PT_W-1:0] point_x_i,
  input  wire logic signed [PT_W-1:0] point_y_i,
  input  wire logic signed [PT_W-1:0] point_z_i,
  input  wire logic                   full_i,
  output logic                        push_o,
  output cand_t                       cand_o
);

  typedef struct packed {
    logic signed [PT_W-1:0] y;
    logic signed [TY_W-1:0] ty;
    logic [LEN_W-1:0]       q;
    logic [LEN_W-1:0]       len;
  } dsb_t;

  logic en;
  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic vs_q [SQRT_LAT];
  logic vd_q [DIV_LAT];

  logic signed [PT_W-1:0] x0_q, y0_q, z0_q, y1_q, y2_q;
  logic [MAG_W-1:0]       xx1_q, zz1_q;
  logic [2*CFG_W-1:0]     hh1_q, rr1_q;
  logic [RAD_W-1:0]       sx2_q, sl2_q;
  logic signed [PT_W-1:0] ys_q [SQRT_LAT];

  logic signed [2*PT_W-1:0] xx_w, zz_w;
  logic [2*CFG_W-1:0]       hh_w, rr_w;
  logic [RAD_W-1:0]         sx_w, sl_w;
  logic [ROOT_W-1:0]        q_w, len_w;

  logic signed [PT_W-1:0] y_s;
  logic [LEN_W-1:0]       q_s, len_s;
  logic signed [TY_W-1:0] ty_w;
  logic signed [NUM_W-1:0] qh_w, tyr_w, qr_w, tyh_w;

  logic signed [NUM_W-1:0] qh3_q, tyr3_q, qr3_q, tyh3_q, n1_4_q, n2_4_q;
  dsb_t sb3_q, sb4_q, sb5_q;
  dsb_t dsb_q [DIV_LAT];

  logic [QUO_W-1:0] mq_w, pq_w;
  logic             mnz, pnz, mneg, pneg;
  logic signed [DIST_W-1:0] mq_ext, pq_ext, mant_w, proj_w;
  logic signed [DIST_W-1:0] mant5_q, proj5_q;

  logic signed [DIST_W-1:0] ny_w, len5_ext;
  logic signed [PT_W-1:0]   neg_y;
  logic [PT_W-1:0]          abs_y;
  logic                     apex, ring;

  assign en         = !(v5_q && full_i);
  assign in_ready_o = en;
  assign push_o     = en && v5_q;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      for (int i = 0; i < SQRT_LAT; i++) vs_q[i] <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) vd_q[i] <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      vs_q[0] <= v2_q;
      for (int i = 1; i < SQRT_LAT; i++) vs_q[i] <= vs_q[i-1];
      v3_q <= vs_q[SQRT_LAT-1];
      v4_q <= v3_q;
      vd_q[0] <= v4_q;
      for (int i = 1; i < DIV_LAT; i++) vd_q[i] <= vd_q[i-1];
      v5_q <= vd_q[DIV_LAT-1];
    end
  end

  // squares and sums feeding the two square roots
  assign xx_w = x0_q * x0_q;
  assign zz_w = z0_q * z0_q;
  assign hh_w = cone_height_i * cone_height_i;
  assign rr_w = cone_radius_i * cone_radius_i;
  assign sx_w = RAD_W'(xx1_q) + RAD_W'(zz1_q);
  assign sl_w = RAD_W'(hh1_q) + RAD_W'(rr1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q  <= point_x_i;
      y0_q  <= point_y_i;
      z0_q  <= point_z_i;
      xx1_q <= xx_w;
      zz1_q <= zz_w;
      hh1_q <= hh_w;
      rr1_q <= rr_w;
      y1_q  <= y0_q;
      sx2_q <= sx_w;
      sl2_q <= sl_w;
      y2_q  <= y1_q;
      ys_q[0] <= y2_q;
      for (int i = 1; i < SQRT_LAT; i++) ys_q[i] <= ys_q[i-1];
    end
  end

  csd_isqrt u_sqrt_q (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sx2_q),
    .root_o (q_w)
  );

  csd_isqrt u_sqrt_len (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sl2_q),
    .root_o (len_w)
  );

  assign y_s   = ys_q[SQRT_LAT-1];
  assign q_s   = q_w[LEN_W-1:0];
  assign len_s = len_w[LEN_W-1:0];

  // mantle and projection numerators
  assign ty_w  = $signed({y_s[PT_W-1], y_s}) - $signed({2'b00, cone_height_i});
  assign qh_w  = $signed({1'b0, q_s}) * $signed({1'b0, cone_height_i});
  assign qr_w  = $signed({1'b0, q_s}) * $signed({1'b0, cone_radius_i});
  assign tyr_w = ty_w * $signed({1'b0, cone_radius_i});
  assign tyh_w = ty_w * $signed({1'b0, cone_height_i});

  always_ff @(posedge clk_i) begin
    if (en) begin
      qh3_q     <= qh_w;
      tyr3_q    <= tyr_w;
      qr3_q     <= qr_w;
      tyh3_q    <= tyh_w;
      sb3_q.y   <= y_s;
      sb3_q.ty  <= ty_w;
      sb3_q.q   <= q_s;
      sb3_q.len <= len_s;
      n1_4_q    <= qh3_q + tyr3_q;
      n2_4_q    <= qr3_q - tyh3_q;
      sb4_q     <= sb3_q;
      dsb_q[0]  <= sb4_q;
      for (int i = 1; i < DIV_LAT; i++) dsb_q[i] <= dsb_q[i-1];
    end
  end

  csd_div u_div_mantle (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (n1_4_q),
    .den_i    (sb4_q.len),
    .quo_o    (mq_w),
    .rem_nz_o (mnz),
    .neg_o    (mneg)
  );

  csd_div u_div_proj (
    .clk_i    (clk_i),
    .en_i     (en),
    .num_i    (n2_4_q),
    .den_i    (sb4_q.len),
    .quo_o    (pq_w),
    .rem_nz_o (pnz),
    .neg_o    (pneg)
  );

  // floor rounding; a degenerate cone gives zero
  assign mq_ext = {1'b0, mq_w};
  assign pq_ext = {1'b0, pq_w};
  assign mant_w = (dsb_q[DIV_LAT-1].len == '0) ? '0 :
                  mneg ? (~mq_ext + {{(DIST_W-1){1'b0}}, ~mnz}) : mq_ext;
  assign proj_w = (dsb_q[DIV_LAT-1].len == '0) ? '0 :
                  pneg ? (~pq_ext + {{(DIST_W-1){1'b0}}, ~pnz}) : pq_ext;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mant5_q <= mant_w;
      proj5_q <= proj_w;
      sb5_q   <= dsb_q[DIV_LAT-1];
    end
  end

  // classify: apex corner, base ring corner, or plain
  assign ny_w     = -sb5_q.y;
  assign neg_y    = -sb5_q.y;
  assign abs_y    = sb5_q.y[PT_W-1] ? neg_y : sb5_q.y;
  assign len5_ext = $signed({{(DIST_W-LEN_W){1'b0}}, sb5_q.len});
  assign apex     = !sb5_q.ty[TY_W-1] && (sb5_q.ty != '0) && proj5_q[DIST_W-1];
  assign ring     = (sb5_q.q > LEN_W'(cone_radius_i)) && (proj5_q > len5_ext);

  always_comb begin
    cand_o.d0  = (mant5_q > ny_w) ? mant5_q : ny_w;
    cand_o.sel = apex || ring;
    if (apex) begin
      cand_o.a = sb5_q.ty[PT_W-1:0];
      cand_o.b = sb5_q.q;
    end else begin
      cand_o.a = sb5_q.q - PT_W'(cone_radius_i);
      cand_o.b = abs_y;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/csd_queue.sv
// Four-entry item queue between the front and back pipelines.
`default_nettype none
module csd_queue import csd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cand_t cand_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output cand_t      cand_o
);

  cand_t              mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cand_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not follow push");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != Q_CNT_W'(Q_DEPTH)) |-> (Q_PTR_W'(wr_q - rd_q) == cnt_q[Q_PTR_W-1:0]))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// File: hw/rtl/csd_back.sv
// Back pipeline: corner distance root, final maximum, saturation and output register.
`default_nettype none
module csd_back import csd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         empty_i,
  input  wire cand_t        cand_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [OUT_W-1:0]  signed_distance_o
);

  logic en;
  logic v0_q, v1_q, v2_q, out_valid_q;
  logic vs_q [SQRT_LAT];

  cand_t                    c0_q;
  logic [MAG_W-1:0]         aa_w, bb_w, aa1_q, bb1_q;
  logic signed [DIST_W-1:0] d1_q, d2_q;
  logic                     s1_q, s2_q;
  logic [RAD_W-1:0]         sum2_q;
  logic signed [DIST_W-1:0] ds_q [SQRT_LAT];
  logic                     ss_q [SQRT_LAT];
  logic [ROOT_W-1:0]        t_w;
  logic signed [DIST_W-1:0] t_ext, dd, dsat;
  logic [OUT_W-1:0]         out_q;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SQRT_LAT; i++) vs_q[i] <= 1'b0;
    end else if (en) begin
      v0_q <= !empty_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      vs_q[0] <= v2_q;
      for (int i = 1; i < SQRT_LAT; i++) vs_q[i] <= vs_q[i-1];
      out_valid_q <= vs_q[SQRT_LAT-1];
    end
  end

  assign aa_w = c0_q.a * c0_q.a;
  assign bb_w = c0_q.b * c0_q.b;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q   <= cand_i;
      aa1_q  <= aa_w;
      bb1_q  <= bb_w;
      d1_q   <= c0_q.d0;
      s1_q   <= c0_q.sel;
      sum2_q <= RAD_W'(aa1_q) + RAD_W'(bb1_q);
      d2_q   <= d1_q;
      s2_q   <= s1_q;
      ds_q[0] <= d2_q;
      ss_q[0] <= s2_q;
      for (int i = 1; i < SQRT_LAT; i++) begin
        ds_q[i] <= ds_q[i-1];
        ss_q[i] <= ss_q[i-1];
      end
      out_q <= dsat[OUT_W-1:0];
    end
  end

  csd_isqrt u_sqrt_t (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum2_q),
    .root_o (t_w)
  );

  assign t_ext = $signed({{(DIST_W-ROOT_W){1'b0}}, t_w});
  assign dd    = (ss_q[SQRT_LAT-1] && (t_ext > ds_q[SQRT_LAT-1])) ? t_ext
                                                                   : ds_q[SQRT_LAT-1];
  assign dsat  = (dd > OUT_MAX) ? OUT_MAX : (dd < OUT_MIN) ? OUT_MIN : dd;

  assign out_valid_o       = out_valid_q;
  assign signed_distance_o = out_q;

endmodule
`default_nettype wire

// File: sim/tb_cone_signed_distance.sv
// Testbench for cone_signed_distance: random and directed points checked against a predictor.
`timescale 1ns / 1ps
module tb_cone_signed_distance;
  import csd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;
  localparam longint ONE = 64'sd1 << FRAC_BITS;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic signed [PT_W-1:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [PT_W-1:0] px = '0, py = '0, pz = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] dist_out;

  point_t pending_points[$];
  logic signed [OUT_W-1:0] expected_dist[$];
  longint unsigned radius_q = RADIUS_RESET, height_q = HEIGHT_RESET;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int mismatches = 0;
  logic hold_req = 1'b0, hold_done = 1'b0;
  int hold_cnt = 0;

  cone_signed_distance dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .point_x_i(px), .point_y_i(py), .point_z_i(pz),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .signed_distance_o(dist_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > v) bits = bits >> 2;
    while (bits != 0) begin
      if (v >= res + bits) begin
        v = v - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint qt;
    qt = n / d;
    if ((n % d) != 0 && n < 0) qt = qt - 1;
    return qt;
  endfunction

  function automatic logic signed [OUT_W-1:0] cone_distance(point_t p);
    longint x, y, z, r, h, q, ty, len, mantle, proj, d, t;
    x = p.x; y = p.y; z = p.z;
    r = longint'(radius_q); h = longint'(height_q);
    q = root_floor(x * x + z * z);
    ty = y - h;
    len = root_floor(h * h + r * r);
    mantle = 0;
    proj = 0;
    if (len != 0) begin
      mantle = div_floor(q * h + ty * r, len);
      proj = div_floor(q * r - ty * h, len);
    end
    d = (mantle > -y) ? mantle : -y;
    if (y > h && proj < 0) begin
      t = root_floor(q * q + ty * ty);
      if (t > d) d = t;
    end
    if (q > r && proj > len) begin
      t = root_floor((q - r) * (q - r) + y * y);
      if (t > d) d = t;
    end
    if (d > longint'(OUT_MAX)) d = OUT_MAX;
    if (d < longint'(OUT_MIN)) d = OUT_MIN;
    return d[OUT_W-1:0];
  endfunction

  // driver
  always @(posedge clk) begin
    logic nxt_valid;
    point_t p;
    nxt_valid = in_valid;
    if (in_valid && in_ready) begin
      expected_dist = {expected_dist, cone_distance('{px, py, pz})};
      nxt_valid = 1'b0;
    end
    if (!nxt_valid && rst_n && pending_points.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      p = pending_points.pop_front();
      px <= p.x; py <= p.y; pz <= p.z;
      nxt_valid = 1'b1;
    end
    in_valid <= nxt_valid;
  end

  // receiver with one long hold-off
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic signed [OUT_W-1:0] exp_d;
    if (out_valid && out_ready) begin
      if (expected_dist.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", dist_out);
      end else begin
        exp_d = expected_dist.pop_front();
        if (exp_d !== dist_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance mismatch: expected %0d got %0d", exp_d, dist_out);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_RADIUS) radius_q = data[CFG_W-1:0];
    else if (idx == REG_HEIGHT) height_q = data[CFG_W-1:0];
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || in_valid || expected_dist.size() != 0)
      @(negedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic add_point(point_t p);
    pending_points = {pending_points, p};
  endtask

  function automatic logic signed [PT_W-1:0] coord(int span);
    case ($urandom_range(3))
      0: return PT_W'($urandom);
      1: return PT_W'(($urandom_range(1) ? -1 : 1) * longint'($urandom_range(span)));
      default: return PT_W'(longint'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  task automatic add_random(int n);
    int span;
    span = int'((radius_q > height_q ? radius_q : height_q) + 2 * ONE);
    if (span > 8000000) span = 8000000;
    repeat (n) add_point('{coord(span), coord(span), coord(span)});
  endtask

  task automatic add_directed();
    longint r, h;
    r = longint'(radius_q); h = longint'(height_q);
    add_point('{24'sd0, 24'sd0, 24'sd0});
    add_point('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
    add_point('{24'h800000, 24'h800000, 24'h800000});
    add_point('{24'h7FFFFF, 24'h800000, 24'h800000});
    add_point('{24'h800000, 24'h7FFFFF, 24'sd0});
    add_point('{24'sd0, 24'h800000, 24'h7FFFFF});
    add_point('{24'sd0, PT_W'(h + ONE), 24'sd0});
    add_point('{PT_W'(r / 8), PT_W'(h + 2 * ONE), 24'sd0});
    add_point('{24'sd0, PT_W'(h), 24'sd0});
    add_point('{PT_W'(r + ONE), -PT_W'(ONE), 24'sd0});
    add_point('{PT_W'(r + 2 * ONE), 24'sd1, PT_W'(ONE)});
    add_point('{PT_W'(r), 24'sd0, 24'sd0});
    add_point('{PT_W'(r / 4), PT_W'(h / 4), -PT_W'(r / 4)});
    add_point('{24'sd0, PT_W'(h / 2), 24'sd0});
    add_point('{-PT_W'(r / 2), -PT_W'(3 * ONE), 24'sd0});
    add_point('{24'sd1, 24'sd1, -24'sd1});
    add_point('{PT_W'(r), PT_W'(h), PT_W'(r)});
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    send_idle_pct = 18; recv_idle_pct = 65;
    add_directed();
    add_random(300);
    drain();

    write_reg(REG_RADIUS, 32'd0);
    write_reg(REG_HEIGHT, 32'd0);
    add_directed();
    add_random(150);
    drain();

    send_idle_pct = 65; recv_idle_pct = 18;
    write_reg(REG_RADIUS, 32'hFFFF_FFFF);
    write_reg(REG_HEIGHT, 32'hFF80_0000 | 32'h7F_FFFF);
    write_reg(REG_UNUSED, 32'd12345);
    add_directed();
    add_random(250);
    drain();

    write_reg(REG_RADIUS, 32'd3 << FRAC_BITS);
    write_reg(REG_HEIGHT, 32'd1);
    add_random(250);
    drain();

    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_RADIUS, $urandom_range(8388607));
    write_reg(REG_HEIGHT, $urandom_range(20 << FRAC_BITS));
    add_directed();
    add_random(350);
    @(posedge clk);
    hold_req <= 1'b1;
    drain();

    write_reg(REG_RADIUS, $urandom_range(8 << FRAC_BITS));
    write_reg(REG_HEIGHT, $urandom_range(8 << FRAC_BITS));
    add_random(300);
    drain();

    if (mismatches == 0 && expected_dist.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/csd_pkg.sv
hw/rtl/csd_isqrt.sv
hw/rtl/csd_div.sv
hw/rtl/csd_front.sv
hw/rtl/csd_queue.sv
hw/rtl/csd_back.sv
hw/rtl/cone_signed_distance.sv
sim/tb_cone_signed_distance.sv
